// ===== sv/gap_buffer_text_store_defines.svh =====
`ifndef GAP_BUFFER_TEXT_STORE_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define GBTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GBTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/gbts_pkg.sv =====
`timescale 1ns / 1ps
package gbts_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned POS_W  = 13;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 13;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_EDIT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

  typedef struct packed {
    logic              status;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  text_length;
  } res_t;

endpackage

// ===== sv/gbts_mem.sv =====
`timescale 1ns / 1ps
module gbts_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                         clk_i,
  input  gbts_pkg::mem_cmd_t           cmd_i,
  input  logic [AW-1:0]                raddr_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [gbts_pkg::CHAR_W-1:0]  wdata_i,
  output logic [gbts_pkg::CHAR_W-1:0]  rdata_o
);

  logic [gbts_pkg::CHAR_W-1:0] mem_q [DEPTH];
  logic [gbts_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gbts_ctrl.sv =====
`timescale 1ns / 1ps
module gbts_ctrl #(
  parameter int unsigned BUFFER_DEPTH = 4096,
  parameter int unsigned AW           = 12,
  parameter int unsigned PW           = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gbts_pkg::FUNC_W-1:0]  func_i,
  input  logic [gbts_pkg::POS_W-1:0]   position_i,
  input  logic [gbts_pkg::CHAR_W-1:0]  char_in_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output gbts_pkg::res_t               res_o,
  output gbts_pkg::mem_cmd_t           mem_cmd_o,
  output logic [AW-1:0]                mem_raddr_o,
  output logic [AW-1:0]                mem_waddr_o,
  output logic [gbts_pkg::CHAR_W-1:0]  mem_wdata_o,
  input  logic [gbts_pkg::CHAR_W-1:0]  mem_rdata_i
);

  // Compare width: wide enough for both the position field and the pointers.
  localparam int unsigned CW = (PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W;

  gbts_pkg::state_e state_q, state_d;

  logic [gbts_pkg::FUNC_W-1:0] func_q, func_d;
  logic [gbts_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [gbts_pkg::CHAR_W-1:0] char_q, char_d;
  logic                        ok_q, ok_d;
  logic [PW-1:0]               gb_q, gb_d;
  logic [PW-1:0]               gf_q, gf_d;

  logic [PW-1:0] gap_size;
  logic [PW-1:0] text_len;
  logic [PW-1:0] gb_dec;
  logic [PW-1:0] gf_dec;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] gb_ext;
  logic [CW-1:0] read_idx;
  logic          is_ins;
  logic          is_del;
  logic          is_rd;
  logic          req_ok;
  logic          go_left;
  logic          go_right;

  assign gap_size = gf_q - gb_q;
  assign text_len = PW'(BUFFER_DEPTH) - gap_size;
  assign gb_dec   = gb_q - PW'(1);
  assign gf_dec   = gf_q - PW'(1);
  assign pos_ext  = CW'(pos_q);
  assign len_ext  = CW'(text_len);
  assign gb_ext   = CW'(gb_q);
  // Bytes before the gap sit at their position; bytes after it are shifted by the gap.
  assign read_idx = (pos_ext < gb_ext) ? pos_ext : (pos_ext + CW'(gap_size));

  assign is_ins = (func_q == gbts_pkg::FUNC_INSERT);
  assign is_del = (func_q == gbts_pkg::FUNC_DELETE);
  assign is_rd  = (func_q == gbts_pkg::FUNC_READ);

  // Unknown func codes fall through to reject.
  always_comb begin
    req_ok = 1'b0;
    if (is_ins) begin
      req_ok = (gap_size != '0) && (pos_ext <= len_ext);
    end else if (is_del || is_rd) begin
      req_ok = (pos_ext < len_ext);
    end
  end

  assign go_left  = (pos_ext < gb_ext);
  assign go_right = (pos_ext > gb_ext);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = gbts_pkg::ST_DECIDE;
        end
      end
      gbts_pkg::ST_DECIDE: begin
        if (req_ok && (is_ins || is_del)) begin
          state_d = gbts_pkg::ST_MOVE_RD;
        end else begin
          state_d = gbts_pkg::ST_RESULT;
        end
      end
      gbts_pkg::ST_MOVE_RD: begin
        if (go_left || go_right) begin
          state_d = gbts_pkg::ST_MOVE_WR;
        end else begin
          state_d = gbts_pkg::ST_EDIT;
        end
      end
      gbts_pkg::ST_MOVE_WR: state_d = gbts_pkg::ST_MOVE_RD;
      gbts_pkg::ST_EDIT:    state_d = gbts_pkg::ST_RESULT;
      gbts_pkg::ST_RESULT: begin
        if (res_ready_i) begin
          state_d = gbts_pkg::ST_IDLE;
        end
      end
      default: state_d = gbts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    func_d      = func_q;
    pos_d       = pos_q;
    char_d      = char_q;
    ok_d        = ok_q;
    gb_d        = gb_q;
    gf_d        = gf_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_cmd_o   = '0;
    mem_raddr_o = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    unique case (state_q)
      gbts_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d = func_i;
          pos_d  = position_i;
          char_d = char_in_i;
        end
      end
      gbts_pkg::ST_DECIDE: begin
        ok_d = req_ok;
        // Read needs no gap move: fetch straight from the store.
        if (is_rd && req_ok) begin
          mem_cmd_o.rd_en = 1'b1;
          mem_raddr_o     = read_idx[AW-1:0];
        end
      end
      gbts_pkg::ST_MOVE_RD: begin
        if (go_left) begin
          mem_cmd_o.rd_en = 1'b1;
          mem_raddr_o     = gb_dec[AW-1:0];
        end else if (go_right) begin
          mem_cmd_o.rd_en = 1'b1;
          mem_raddr_o     = gf_q[AW-1:0];
        end
      end
      gbts_pkg::ST_MOVE_WR: begin
        mem_cmd_o.wr_en = 1'b1;
        mem_wdata_o     = mem_rdata_i;
        if (go_left) begin
          mem_waddr_o = gf_dec[AW-1:0];
          gb_d        = gb_dec;
          gf_d        = gf_dec;
        end else begin
          mem_waddr_o = gb_q[AW-1:0];
          gb_d        = gb_q + PW'(1);
          gf_d        = gf_q + PW'(1);
        end
      end
      gbts_pkg::ST_EDIT: begin
        if (is_ins) begin
          mem_cmd_o.wr_en = 1'b1;
          mem_waddr_o     = gb_q[AW-1:0];
          mem_wdata_o     = char_q;
          gb_d            = gb_q + PW'(1);
        end else begin
          gf_d = gf_q + PW'(1);
        end
      end
      gbts_pkg::ST_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_o.status      = !ok_q;
    res_o.char_out    = (ok_q && is_rd) ? mem_rdata_i : '0;
    res_o.text_length = gbts_pkg::LEN_W'(text_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbts_pkg::ST_IDLE;
      ok_q    <= 1'b0;
      gb_q    <= '0;
      gf_q    <= PW'(BUFFER_DEPTH);
    end else begin
      state_q <= state_d;
      ok_q    <= ok_d;
      gb_q    <= gb_d;
      gf_q    <= gf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    pos_q  <= pos_d;
    char_q <= char_d;
  end

endmodule

// ===== sv/gap_buffer_text_store.sv =====
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+-------------------------------
// in      | input     | in_valid_i / in_ready_o   | func_i, position_i, char_in_i
// out     | output    | out_valid_o / out_ready_i | status_o, char_out_o,
//         |           |                           | text_length_o
//
// A read or rejected request steps through DECIDE and RESULT to the result register;
//   insert and delete add a MOVE_RD/MOVE_WR pair per byte of gap move, then EDIT.
// The gap move sets the pace: one byte at a time over the single text memory
//   (read a byte, then write it across the gap).
// Reset clears the gap pointers (empty text) and control state; the text memory is not cleared.
// A new transaction is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`include "gap_buffer_text_store_defines.svh"
module gap_buffer_text_store #(
  parameter int unsigned BUFFER_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gbts_pkg::FUNC_W-1:0]  func_i,
  input  logic [gbts_pkg::POS_W-1:0]   position_i,
  input  logic [gbts_pkg::CHAR_W-1:0]  char_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [gbts_pkg::CHAR_W-1:0]  char_out_o,
  output logic [gbts_pkg::LEN_W-1:0]   text_length_o
);

  // Memory address width and gap pointer width (pointers reach BUFFER_DEPTH).
  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);

  gbts_pkg::mem_cmd_t          mem_cmd;
  logic [AW-1:0]               mem_raddr;
  logic [AW-1:0]               mem_waddr;
  logic [gbts_pkg::CHAR_W-1:0] mem_wdata;
  logic [gbts_pkg::CHAR_W-1:0] mem_rdata;

  logic           res_valid;
  logic           res_ready;
  gbts_pkg::res_t res;

  logic           out_valid_q, out_valid_d;
  gbts_pkg::res_t out_res_q, out_res_d;

  // Sequencer: owns the gap pointers and walks the gap to the requested spot.
  gbts_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW),
    .PW           (PW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .position_i  (position_i),
    .char_in_i   (char_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_cmd_o   (mem_cmd),
    .mem_raddr_o (mem_raddr),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // Text store: one write port, one registered read port.
  gbts_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .raddr_i (mem_raddr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: take a new result when empty or draining this cycle,
  // otherwise hold the sequencer in its result state.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign char_out_o    = out_res_q.char_out;
  assign text_length_o = out_res_q.text_length;

  // One transaction in flight: the sequencer drops ready right after an accept.
  `GBTS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready held after accept")
  // A finished result always lands in the output register.
  `GBTS_ASSERT_NEXT(a_result_lands, clk_i, rst_ni, res_valid && res_ready, out_valid_o, "result lost")
  // Rejected transactions carry a zero byte.
  `GBTS_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, out_valid_o && status_o, char_out_o == '0, "reject with data")

endmodule
